### hdl/m2q_pkg.sv
// Shared types, constants and step functions for the matrix to quaternion pipeline.
package m2q_pkg;

    localparam int FW       = 18;   // field width, signed Q2.16
    localparam int SQ_STEPS = 18;   // root bits
    localparam int DV_STEPS = 18;   // quotient bits
    localparam int ST_IN    = 0;
    localparam int ST_PRE   = 1;
    localparam int ST_SQ0   = 2;
    localparam int ST_DV0   = ST_SQ0 + SQ_STEPS + 1;
    localparam int ST_OUT   = ST_DV0 + DV_STEPS + 1;
    localparam int NSTG     = ST_OUT + 1;

    localparam logic signed [19:0] ONE_Q16  = 20'sd65536;
    localparam logic [17:0]        POS_MAX  = 18'd131071;
    localparam logic [17:0]        NEG_MAG  = 18'd131072;

    // output slot that receives half the root
    typedef enum logic [1:0] {
        SLOT_W = 2'd0,
        SLOT_X = 2'd1,
        SLOT_Y = 2'd2,
        SLOT_Z = 2'd3
    } slot_t;

    typedef struct packed {
        logic              trace_br;
        logic [1:0]        piv;
        logic signed [19:0] rad_t;
        logic signed [19:0] rad_0;
        logic signed [19:0] rad_1;
        logic signed [19:0] rad_2;
        logic signed [18:0] d12m;
        logic signed [18:0] d20m;
        logic signed [18:0] d01m;
        logic signed [18:0] d01p;
        logic signed [18:0] d12p;
        logic signed [18:0] d02p;
    } pre_t;

    typedef struct packed {
        slot_t            slot;
        logic [2:0]       neg;
        logic [2:0][18:0] mag;
    } side_t;

    typedef struct packed {
        side_t       side;
        logic [35:0] rad;
        logic [21:0] rem;
        logic [17:0] root;
    } sq_t;

    typedef struct packed {
        slot_t            slot;
        logic [2:0]       neg;
        logic             zero;
        logic [17:0]      half;
        logic [17:0]      r;
        logic [2:0]       ovf;
        logic [2:0][17:0] rem;
        logic [2:0][17:0] num;
        logic [2:0][17:0] q;
    } dv_t;

    // One digit of the bitwise square root.
    function automatic sq_t sq_step(input sq_t s);
        sq_t         o;
        logic [21:0] rem2;
        logic [21:0] trial;
        o     = s;
        rem2  = {s.rem[19:0], s.rad[35:34]};
        trial = {2'b00, s.root, 2'b01};
        o.rad = {s.rad[33:0], 2'b00};
        if (rem2 >= trial) begin
            o.rem  = rem2 - trial;
            o.root = {s.root[16:0], 1'b1};
        end else begin
            o.rem  = rem2;
            o.root = {s.root[16:0], 1'b0};
        end
        return o;
    endfunction

    // One quotient bit of restoring division for all three components.
    function automatic dv_t dv_step(input dv_t d);
        dv_t         o;
        logic [18:0] r2;
        o = d;
        for (int c = 0; c < 3; c++) begin
            r2       = {d.rem[c], d.num[c][17]};
            o.num[c] = {d.num[c][16:0], 1'b0};
            if (r2 >= {1'b0, d.r}) begin
                o.rem[c] = 18'(r2 - {1'b0, d.r});
                o.q[c]   = {d.q[c][16:0], 1'b1};
            end else begin
                o.rem[c] = r2[17:0];
                o.q[c]   = {d.q[c][16:0], 1'b0};
            end
        end
        return o;
    endfunction

    // Apply sign and saturate one scaled component.
    function automatic logic [17:0] sat_comp(input logic zero, input logic neg,
                                             input logic ovf, input logic [17:0] q);
        logic [17:0] res;
        if (zero) begin
            res = '0;
        end else if (!neg) begin
            res = (ovf || q > POS_MAX) ? POS_MAX : q;
        end else begin
            res = (ovf || q > NEG_MAG) ? NEG_MAG : 18'(-q);
        end
        return res;
    endfunction

endpackage

### hdl/matrix_to_quaternion.sv
// Rotation matrix to unit quaternion converter, fully pipelined.
//
// Channel | Direction | tdata fields (low bit up)                      | tuser/tlast
// s_      | in        | elem_00,01,02,10,11,12,20,21,22 (18b each)     | none
// m_      | out       | quat_w, quat_x, quat_y, quat_z (18b each)      | none
//
// One transaction per cycle is accepted unless the output stalls; the pipeline
// holds an 18-step square root and an 18-step divider, one bit per stage each.
// aresetn (synchronous, active low) clears every stage valid bit.
// Each stage holds while the next is full and stalled; bubbles close up.
module matrix_to_quaternion (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [167:0]  s_tdata,   // elem_00,01,02,10,11,12,20,21,22; top 6 bits zero
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [71:0]   m_tdata    // quat_w, quat_x, quat_y, quat_z
);
    import m2q_pkg::*;

    logic [NSTG-1:0]        v_reg;
    logic [NSTG:0]          rdy;
    logic signed [17:0]     m_reg [9];
    pre_t                   pre_reg;
    pre_t                   pre_next;
    sq_t                    sq_reg [SQ_STEPS+1];
    sq_t                    sq_init;
    dv_t                    dv_reg [DV_STEPS+1];
    dv_t                    dv_init;
    logic [71:0]            out_reg;
    logic [71:0]            out_next;

    // Stage ready chain: a stage loads when empty or when it moves on
    always_comb begin
        rdy[NSTG] = m_tready;
        for (int n = NSTG - 1; n >= 0; n--) begin
            rdy[n] = !v_reg[n] || rdy[n+1];
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = v_reg[ST_OUT];
    assign m_tdata  = out_reg;

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) begin
                v_reg[0] <= s_tvalid;
            end
            for (int n = 1; n < NSTG; n++) begin
                if (rdy[n]) begin
                    v_reg[n] <= v_reg[n-1];
                end
            end
        end
    end

    // Capture the matrix
    always_ff @(posedge aclk) begin
        if (rdy[ST_IN]) begin
            for (int e = 0; e < 9; e++) begin
                m_reg[e] <= s_tdata[e*FW +: FW];
            end
        end
    end

    // Trace, pivot choice, radicands and off-diagonal sums
    always_comb begin
        logic signed [19:0] e00, e11, e22;
        logic [1:0]         p;
        logic signed [17:0] dmax;
        e00 = 20'(m_reg[0]);
        e11 = 20'(m_reg[4]);
        e22 = 20'(m_reg[8]);
        p    = 2'd0;
        dmax = m_reg[0];
        if (m_reg[4] > m_reg[0]) begin
            p    = 2'd1;
            dmax = m_reg[4];
        end
        if (m_reg[8] > dmax) begin
            p = 2'd2;
        end
        pre_next.piv      = p;
        pre_next.rad_t    = e00 + e11 + e22 + ONE_Q16;
        pre_next.trace_br = pre_next.rad_t > 20'sd1;
        pre_next.rad_0    = e00 - (e11 + e22) + ONE_Q16;
        pre_next.rad_1    = e11 - (e22 + e00) + ONE_Q16;
        pre_next.rad_2    = e22 - (e00 + e11) + ONE_Q16;
        pre_next.d12m     = 19'(m_reg[5]) - 19'(m_reg[7]);
        pre_next.d20m     = 19'(m_reg[6]) - 19'(m_reg[2]);
        pre_next.d01m     = 19'(m_reg[1]) - 19'(m_reg[3]);
        pre_next.d01p     = 19'(m_reg[1]) + 19'(m_reg[3]);
        pre_next.d12p     = 19'(m_reg[5]) + 19'(m_reg[7]);
        pre_next.d02p     = 19'(m_reg[2]) + 19'(m_reg[6]);
    end

    always_ff @(posedge aclk) begin
        if (rdy[ST_PRE]) begin
            pre_reg <= pre_next;
        end
    end

    // Pick branch terms and seed the root
    always_comb begin
        logic signed [19:0] a;
        logic signed [18:0] da, db, dc;
        if (pre_reg.trace_br) begin
            a = pre_reg.rad_t;
            sq_init.side.slot = SLOT_W;
            da = pre_reg.d12m; db = pre_reg.d20m; dc = pre_reg.d01m;
        end else begin
            case (pre_reg.piv)
                2'd0: begin
                    a = pre_reg.rad_0;
                    sq_init.side.slot = SLOT_X;
                    da = pre_reg.d12m; db = pre_reg.d01p; dc = pre_reg.d02p;
                end
                2'd1: begin
                    a = pre_reg.rad_1;
                    sq_init.side.slot = SLOT_Y;
                    da = pre_reg.d20m; db = pre_reg.d12p; dc = pre_reg.d01p;
                end
                default: begin
                    a = pre_reg.rad_2;
                    sq_init.side.slot = SLOT_Z;
                    da = pre_reg.d01m; db = pre_reg.d02p; dc = pre_reg.d12p;
                end
            endcase
        end
        sq_init.side.neg    = {dc[18], db[18], da[18]};
        sq_init.side.mag[0] = da[18] ? 19'(-da) : 19'(da);
        sq_init.side.mag[1] = db[18] ? 19'(-db) : 19'(db);
        sq_init.side.mag[2] = dc[18] ? 19'(-dc) : 19'(dc);
        sq_init.rad  = (a <= 20'sd0) ? '0 : {1'b0, a[18:0], 16'b0};
        sq_init.rem  = '0;
        sq_init.root = '0;
    end

    // Square root, one bit per stage
    always_ff @(posedge aclk) begin
        if (rdy[ST_SQ0]) begin
            sq_reg[0] <= sq_init;
        end
        for (int k = 1; k <= SQ_STEPS; k++) begin
            if (rdy[ST_SQ0+k]) begin
                sq_reg[k] <= sq_step(sq_reg[k-1]);
            end
        end
    end

    // Form rounded numerators and detect quotient overflow
    always_comb begin
        logic [17:0] r;
        logic [33:0] nn;
        logic [18:0] h;
        r = sq_reg[SQ_STEPS].root;
        h = ({1'b0, r} + 19'd1) >> 1;
        dv_init.slot = sq_reg[SQ_STEPS].side.slot;
        dv_init.neg  = sq_reg[SQ_STEPS].side.neg;
        dv_init.zero = (r == '0);
        dv_init.half = h[17:0];
        dv_init.r    = r;
        for (int c = 0; c < 3; c++) begin
            nn = {sq_reg[SQ_STEPS].side.mag[c], 15'b0} + {17'b0, r[17:1]};
            dv_init.ovf[c] = {2'b00, nn} >= {r, 18'b0};
            dv_init.rem[c] = {2'b00, nn[33:18]};
            dv_init.num[c] = nn[17:0];
            dv_init.q[c]   = '0;
        end
    end

    // Division, one quotient bit per stage
    always_ff @(posedge aclk) begin
        if (rdy[ST_DV0]) begin
            dv_reg[0] <= dv_init;
        end
        for (int k = 1; k <= DV_STEPS; k++) begin
            if (rdy[ST_DV0+k]) begin
                dv_reg[k] <= dv_step(dv_reg[k-1]);
            end
        end
    end

    // Saturate and route components to their slots
    always_comb begin
        dv_t         d;
        logic [17:0] ca, cb, cc;
        d  = dv_reg[DV_STEPS];
        ca = sat_comp(d.zero, d.neg[0], d.ovf[0], d.q[0]);
        cb = sat_comp(d.zero, d.neg[1], d.ovf[1], d.q[1]);
        cc = sat_comp(d.zero, d.neg[2], d.ovf[2], d.q[2]);
        case (d.slot)
            SLOT_W:  out_next = {cc, cb, ca, d.half};
            SLOT_X:  out_next = {cc, cb, d.half, ca};
            SLOT_Y:  out_next = {cb, d.half, cc, ca};
            SLOT_Z:  out_next = {d.half, cc, cb, ca};
            default: out_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rdy[ST_OUT]) begin
            out_reg <= out_next;
        end
    end

`ifndef SYNTHESIS
    // An empty output register never blocks the input
    a_ready_when_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !v_reg[ST_OUT] |-> s_tready)
        else $error("input stalled with empty output stage");

    // An empty pipeline produces no transaction next cycle
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        ($countones(v_reg) == 0 && !s_tvalid) |=> !m_tvalid)
        else $error("output valid from empty pipeline");

    // Reset leaves no valid stage
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> (v_reg == '0))
        else $error("valid bit survived reset");

    // A zero root yields a zero half-root component
    a_zero_half: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[ST_DV0] && dv_reg[0].zero) |-> (dv_reg[0].half == '0))
        else $error("zero root with nonzero half");
`endif

endmodule

### test/matrix_to_quaternion_tb.sv
// Testbench for the matrix to quaternion converter: directed and random matrices.
`timescale 1ns / 100ps

module matrix_to_quaternion_tb;

    localparam int LATENCY    = 41;
    localparam int STALL_LONG = 150;
    localparam int IDLE_LIMIT = 5000;

    typedef struct {
        logic signed [17:0] w;
        logic signed [17:0] x;
        logic signed [17:0] y;
        logic signed [17:0] z;
    } quat_t;

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    logic [167:0]  s_tdata;
    logic          m_tvalid;
    logic          m_tready;
    logic [71:0]   m_tdata;

    quat_t expected_quats[$];
    int    error_count;
    int    matrices_sent;
    int    quats_checked;
    int    trace_branch_cnt;
    int    pivot_branch_cnt;
    int    idle_cycles;
    bit    hold_off_rx;
    bit    rx_gaps_on;
    bit    tx_gaps_on;

    matrix_to_quaternion dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Integer square root of a nonnegative value.
    function automatic longint unsigned int_sqrt(input longint unsigned a);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > a) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (a >= res + bitv) begin
                a   = a - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint clamp18(input longint v);
        if (v > 131071) return 131071;
        if (v < -131072) return -131072;
        return v;
    endfunction

    // Root of a Q16 radicand, zero at or below zero.
    function automatic longint unsigned q16_root(input longint a);
        if (a <= 0) return 0;
        return int_sqrt(longint'(a) << 16);
    endfunction

    // Difference d times 2^15 over the root, rounded away from zero on ties.
    function automatic longint div_by_root(input longint d, input longint unsigned r);
        longint unsigned mag;
        longint unsigned quo;
        if (r == 0) return 0;
        mag = (d < 0) ? longint'(-d) : longint'(d);
        quo = ((mag << 15) + (r >> 1)) / r;
        if (quo > (64'd1 << 20)) quo = 64'd1 << 20;
        return clamp18(d < 0 ? -longint'(quo) : longint'(quo));
    endfunction

    // Predict the quaternion of one matrix.
    function automatic quat_t shepperd_quat(input logic [167:0] data);
        longint          m[3][3];
        longint          comp[4];
        longint          tr;
        longint unsigned r;
        int              i;
        int              j;
        int              k;
        quat_t           res;
        for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
                m[a][b] = longint'($signed(data[(a*3+b)*18 +: 18]));
        tr = m[0][0] + m[1][1] + m[2][2] + 65536;
        if (tr > 1) begin
            r       = q16_root(tr);
            comp[3] = clamp18((r + 1) >> 1);
            comp[0] = div_by_root(m[1][2] - m[2][1], r);
            comp[1] = div_by_root(m[2][0] - m[0][2], r);
            comp[2] = div_by_root(m[0][1] - m[1][0], r);
        end else begin
            i = 0;
            if (m[1][1] > m[0][0]) i = 1;
            if (m[2][2] > m[i][i]) i = 2;
            j = (i + 1) % 3;
            k = (j + 1) % 3;
            r       = q16_root(m[i][i] - (m[j][j] + m[k][k]) + 65536);
            comp[i] = clamp18((r + 1) >> 1);
            comp[3] = div_by_root(m[j][k] - m[k][j], r);
            comp[j] = div_by_root(m[i][j] + m[j][i], r);
            comp[k] = div_by_root(m[i][k] + m[k][i], r);
        end
        res.w = comp[3][17:0];
        res.x = comp[0][17:0];
        res.y = comp[1][17:0];
        res.z = comp[2][17:0];
        return res;
    endfunction

    function automatic logic [167:0] pack_matrix(input int e[9]);
        logic [167:0] d;
        d = '0;
        for (int n = 0; n < 9; n++) d[n*18 +: 18] = e[n][17:0];
        return d;
    endfunction

    // Send one matrix and queue its expected quaternion; valid stays up afterwards.
    task automatic send_matrix(input int e[9]);
        logic signed [17:0] d00;
        logic signed [17:0] d11;
        logic signed [17:0] d22;
        int gap;
        gap = tx_gaps_on ? $urandom_range(0, 14) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_matrix(e);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        d00 = e[0][17:0];
        d11 = e[4][17:0];
        d22 = e[8][17:0];
        if (32'(d00) + 32'(d11) + 32'(d22) + 65536 > 1) trace_branch_cnt++;
        else pivot_branch_cnt++;
        expected_quats.push_back(shepperd_quat(pack_matrix(e)));
        matrices_sent++;
    endtask

    // Drop valid and wait until every expected quaternion has arrived.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_quats.size() != 0) @(posedge aclk);
    endtask

    // Random entry, mostly near a rotation, sometimes extreme.
    function automatic int rand_elem();
        case ($urandom_range(0, 5))
            0: return -131072;
            1: return 131071;
            2: return int'($urandom_range(0, 262143)) - 131072;
            default: return int'($urandom_range(0, 131072)) - 65536;
        endcase
    endfunction

    task automatic test_directed();
        int e[9];
        // identity and extremes
        e = '{65536, 0, 0, 0, 65536, 0, 0, 0, 65536};          send_matrix(e);
        e = '{131071, 131071, 131071, 131071, 131071, 131071,
              131071, 131071, 131071};                          send_matrix(e);
        e = '{-131072, -131072, -131072, -131072, -131072, -131072,
              -131072, -131072, -131072};                       send_matrix(e);
        e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                       send_matrix(e);
        // trace plus one at and around the threshold
        e = '{-65535, 5, 7, 3, 0, -9, 1, 2, 0};                 send_matrix(e);
        e = '{-65534, 5, 7, 3, 0, -9, 1, 2, 0};                 send_matrix(e);
        e = '{-65536, 5, 7, 3, 0, -9, 1, 2, 0};                 send_matrix(e);
        // pivot on each axis: 180 degree rotations
        e = '{65536, 0, 0, 0, -65536, 0, 0, 0, -65536};         send_matrix(e);
        e = '{-65536, 0, 0, 0, 65536, 0, 0, 0, -65536};         send_matrix(e);
        e = '{-65536, 0, 0, 0, -65536, 0, 0, 0, 65536};         send_matrix(e);
        // diagonal ties keep the lower axis
        e = '{-32768, 100, 200, 300, -32768, 400, 500, 600, -32768}; send_matrix(e);
        e = '{-70000, 100, 200, 300, -30000, 400, 500, 600, -30000}; send_matrix(e);
        // pivot branch with full-scale and mixed-sign diagonals
        e = '{-131072, 900, -800, 700, -131072, 600, -500, 400, -131072}; send_matrix(e);
        e = '{-65536, 1, 2, 3, -65536, 4, 5, 6, 65536};         send_matrix(e);
        // tiny root with saturated components, then a large pivot radicand
        e = '{-65534, 131071, -131072, -131072, 0, 131071, 131071, -131072, 0};
        send_matrix(e);
        e = '{-131072, 131071, 131071, 131071, 131071, 131071,
              131071, 131071, -131072};                         send_matrix(e);
        // 90 degrees about z
        e = '{0, -65536, 0, 65536, 0, 0, 0, 0, 65536};          send_matrix(e);
        wait_drained();
    endtask

    task automatic test_random(input int count);
        int e[9];
        for (int n = 0; n < count; n++) begin
            for (int c = 0; c < 9; c++) e[c] = rand_elem();
            // push part of the set into the pivot branch
            if ($urandom_range(0, 2) == 0) begin
                e[0] = -int'($urandom_range(0, 131072));
                e[4] = -int'($urandom_range(0, 131072));
                e[8] = -65537 - e[0] - e[4] + int'($urandom_range(0, 2));
                if (e[8] < -131072) e[8] = -131072;
                if (e[8] > 131071) e[8] = 131071;
            end
            send_matrix(e);
        end
    endtask

    // Keep the receiver stalled while the sender fills the pipeline.
    task automatic test_backpressure();
        hold_off_rx = 1'b1;
        tx_gaps_on  = 1'b0;
        fork
            test_random(80);
            begin
                repeat (STALL_LONG) @(posedge aclk);
                hold_off_rx = 1'b0;
            end
        join
        tx_gaps_on = 1'b1;
        wait_drained();
    endtask

    // Receiver: random readiness, held low for the whole hold-off stretch.
    initial begin
        int gap;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = (rx_gaps_on && !hold_off_rx) ? $urandom_range(0, 14) : 0;
            if (hold_off_rx || gap != 0) begin
                m_tready <= 1'b0;
                if (hold_off_rx) begin
                    while (hold_off_rx) @(posedge aclk);
                end else begin
                    repeat (gap) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // Compare each quaternion with the oldest prediction.
    always @(posedge aclk) begin
        quat_t want;
        logic signed [17:0] got[4];
        if (aresetn && m_tvalid && m_tready) begin
            for (int c = 0; c < 4; c++) got[c] = m_tdata[c*18 +: 18];
            if (expected_quats.size() == 0) begin
                $display("%0t: unexpected quaternion %h", $time, m_tdata);
                error_count++;
            end else begin
                want = expected_quats.pop_front();
                if (got[0] !== want.w) begin
                    $display("%0t: w expected %0d actual %0d", $time, want.w, got[0]);
                    error_count++;
                end
                if (got[1] !== want.x) begin
                    $display("%0t: x expected %0d actual %0d", $time, want.x, got[1]);
                    error_count++;
                end
                if (got[2] !== want.y) begin
                    $display("%0t: y expected %0d actual %0d", $time, want.y, got[2]);
                    error_count++;
                end
                if (got[3] !== want.z) begin
                    $display("%0t: z expected %0d actual %0d", $time, want.z, got[3]);
                    error_count++;
                end
            end
            quats_checked++;
        end
    end

    // Watchdog on cycles with no transaction.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("matrix_to_quaternion: mismatch");
            $finish;
        end
    end

    initial begin
        error_count      = 0;
        matrices_sent    = 0;
        quats_checked    = 0;
        trace_branch_cnt = 0;
        pivot_branch_cnt = 0;
        idle_cycles      = 0;
        hold_off_rx      = 1'b0;
        rx_gaps_on       = 1'b1;
        tx_gaps_on       = 1'b1;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random(300);
        test_backpressure();
        rx_gaps_on = 1'b0;
        tx_gaps_on = 1'b0;
        test_random(200);
        rx_gaps_on = 1'b1;
        tx_gaps_on = 1'b1;
        test_random(200);

        wait_drained();
        repeat (LATENCY + 10) @(posedge aclk);
        $display("Sent %0d matrices, checked %0d quaternions (%0d trace, %0d pivot).",
                 matrices_sent, quats_checked, trace_branch_cnt, pivot_branch_cnt);
        if (error_count == 0 && expected_quats.size() == 0) begin
            $display("matrix_to_quaternion: match");
        end else begin
            $display("matrix_to_quaternion: mismatch");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/m2q_pkg.sv
hdl/matrix_to_quaternion.sv
test/matrix_to_quaternion_tb.sv
